### sv/mrc_pkg.sv
// mrc_pkg: shared types, constants and the crc-16 byte update for the
// modbus response checker. No dependencies.
`timescale 1ns / 1ps

package mrc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int COUNT_W         = 9;
    localparam int ADDR_W          = 3;

    localparam logic [15:0]        CRC_INIT      = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY      = 16'hA001;
    localparam logic [7:0]         EXC_MASK      = 8'b1000_0000;
    localparam logic [7:0]         SLAVE_ID_INIT = 8'd1;
    localparam logic [COUNT_W-1:0] MIN_FRAME     = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] MAX_KEPT      = COUNT_W'(MAX_FRAME_BYTES);

    localparam logic [ADDR_W-1:0]  ADDR_SLAVE_ID = ADDR_W'(0);

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_WRONG_SLAVE = 3'd1,
        ST_BAD_CRC     = 3'd2,
        ST_EXCEPTION   = 3'd3,
        ST_TOO_SHORT   = 3'd4
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         exception_code;
        status_t            status;
    } result_t;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/modbus_response_checker_core.sv
// modbus_response_checker_core: top level with input register, frame tracker, result register
// and apb config; depends on mrc_pkg, mrc_frame_tracker, mrc_apb_regs.
// m_tvalid rises once a last byte leaves the input register and its result is registered.
// Throughput: one byte per cycle; a last byte waits in the input register only while the
//   result register is full and m_tready is low.
// Reset: synchronous active-low aresetn empties both registers, restores frame state, slave_id 1.
`timescale 1ns / 1ps

module modbus_response_checker_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // rx_byte[7:0]
    input  logic                       s_tlast,   // last_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // status[2:0], exception_code[10:3],
                                                  // byte_count[19:11], zero[23:20]
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mrc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg,  in_byte_next;
    logic             in_last_reg,  in_last_next;
    logic             out_valid_reg, out_valid_next;
    mrc_pkg::result_t out_data_reg,  out_data_next;

    logic             advance;
    logic [7:0]       slave_id;
    mrc_pkg::result_t result;

    mrc_apb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .slave_id (slave_id)
    );

    mrc_frame_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .rx_byte   (in_byte_reg),
        .last_byte (in_last_reg),
        .slave_id  (slave_id),
        .result    (result)
    );

    // only a last byte needs room in the result register
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_last_next   = in_last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_byte_reg  <= in_byte_next;
        in_last_reg  <= in_last_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_data_reg};

    a_last_makes_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> out_valid_reg)
        else $error("last byte did not produce a result");

    a_ok_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.status == mrc_pkg::ST_OK |->
        out_data_reg.byte_count >= mrc_pkg::MIN_FRAME
        && out_data_reg.byte_count <= mrc_pkg::MAX_KEPT)
        else $error("ok result with impossible byte count");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
        (out_data_reg.status == mrc_pkg::ST_OK || out_data_reg.byte_count == '0)
        && (out_data_reg.status == mrc_pkg::ST_EXCEPTION
            || out_data_reg.exception_code == 8'h00))
        else $error("result field set for wrong status");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
        && $stable(in_last_reg))
        else $error("stalled input register lost its byte");

endmodule

### sv/mrc_apb_regs.sv
// mrc_apb_regs: apb register file holding the expected slave address.
// Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_apb_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [mrc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [7:0]                slave_id
);

    logic [7:0] slave_id_reg;
    logic [7:0] slave_id_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr == mrc_pkg::ADDR_SLAVE_ID);

    always_comb begin
        slave_id_next = slave_id_reg;
        if (wr_en) begin
            slave_id_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_id_reg <= mrc_pkg::SLAVE_ID_INIT;
        end else begin
            slave_id_reg <= slave_id_next;
        end
    end

    assign prdata   = (paddr == mrc_pkg::ADDR_SLAVE_ID) ? {24'h000000, slave_id_reg} : 32'h0;
    assign slave_id = slave_id_reg;

endmodule

### sv/mrc_frame_tracker.sv
// mrc_frame_tracker: per-frame state (crc, two-byte tail, header bytes,
// count) and the end-of-frame checks. Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_frame_tracker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [7:0]       rx_byte,
    input  logic             last_byte,
    input  logic [7:0]       slave_id,
    output mrc_pkg::result_t result
);

    logic [15:0]                 crc_reg,    crc_next;
    logic [7:0]                  older_reg,  older_next;
    logic [7:0]                  newer_reg,  newer_next;
    logic [mrc_pkg::COUNT_W-1:0] count_reg,  count_next;
    logic [7:0]                  first_reg,  first_next;
    logic [7:0]                  func_reg,   func_next;
    logic [7:0]                  third_reg,  third_next;

    logic [15:0]                 crc_upd;
    logic [7:0]                  older_upd, newer_upd, first_upd, func_upd, third_upd;
    logic [mrc_pkg::COUNT_W-1:0] count_upd;

    always_comb begin
        crc_upd   = crc_reg;
        older_upd = older_reg;
        newer_upd = newer_reg;
        count_upd = count_reg;
        first_upd = first_reg;
        func_upd  = func_reg;
        third_upd = third_reg;
        // bytes past the limit are dropped
        if (count_reg < mrc_pkg::MAX_KEPT) begin
            if (count_reg >= mrc_pkg::COUNT_W'(2)) begin
                crc_upd = mrc_pkg::crc_update(crc_reg, older_reg);
            end
            older_upd = newer_reg;
            newer_upd = rx_byte;
            if (count_reg == mrc_pkg::COUNT_W'(0)) begin
                first_upd = rx_byte;
            end else if (count_reg == mrc_pkg::COUNT_W'(1)) begin
                func_upd = rx_byte;
            end else if (count_reg == mrc_pkg::COUNT_W'(2)) begin
                third_upd = rx_byte;
            end
            count_upd = count_reg + mrc_pkg::COUNT_W'(1);
        end
    end

    always_comb begin
        result.status         = mrc_pkg::ST_OK;
        result.exception_code = 8'h00;
        result.byte_count     = '0;
        if (count_upd < mrc_pkg::MIN_FRAME) begin
            result.status = mrc_pkg::ST_TOO_SHORT;
        end else if (first_upd != slave_id) begin
            result.status = mrc_pkg::ST_WRONG_SLAVE;
        end else if (crc_upd[7:0] != older_upd || crc_upd[15:8] != newer_upd) begin
            result.status = mrc_pkg::ST_BAD_CRC;
        end else if ((func_upd & mrc_pkg::EXC_MASK) == mrc_pkg::EXC_MASK) begin
            result.status         = mrc_pkg::ST_EXCEPTION;
            result.exception_code = third_upd;
        end else begin
            result.byte_count = count_upd;
        end
    end

    always_comb begin
        crc_next   = crc_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        count_next = count_reg;
        first_next = first_reg;
        func_next  = func_reg;
        third_next = third_reg;
        if (step_en) begin
            if (last_byte) begin
                // frame done, start over
                crc_next   = mrc_pkg::CRC_INIT;
                older_next = 8'h00;
                newer_next = 8'h00;
                count_next = '0;
                first_next = 8'h00;
                func_next  = 8'h00;
                third_next = 8'h00;
            end else begin
                crc_next   = crc_upd;
                older_next = older_upd;
                newer_next = newer_upd;
                count_next = count_upd;
                first_next = first_upd;
                func_next  = func_upd;
                third_next = third_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= mrc_pkg::CRC_INIT;
            older_reg <= 8'h00;
            newer_reg <= 8'h00;
            count_reg <= '0;
            first_reg <= 8'h00;
            func_reg  <= 8'h00;
            third_reg <= 8'h00;
        end else begin
            crc_reg   <= crc_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            count_reg <= count_next;
            first_reg <= first_next;
            func_reg  <= func_next;
            third_reg <= third_next;
        end
    end

endmodule
